[src/ckpr_pkg.sv]
// shared types and constants for the chroma key pixel replace pipeline
package ckpr_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_RED_RANGE   = 3'd0;
  localparam logic [2:0] REG_GREEN_RANGE = 3'd1;
  localparam logic [2:0] REG_BLUE_RANGE  = 3'd2;
  localparam logic [2:0] REG_SOFTEN      = 3'd3;
  localparam logic [2:0] REG_CLEAR       = 3'd4;
  localparam logic [2:0] REG_MODE        = 3'd5;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned INDEX_W  = 3;
  localparam int unsigned CFG_W    = 24;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
    chan_t a;
  } pixel_t;

  // one key range: high bound over low bound
  typedef struct packed {
    chan_t hi;
    chan_t lo;
  } range_t;

  typedef struct packed {
    chan_t b;
    chan_t g;
    chan_t r;
  } colour_t;

  typedef struct packed {
    logic white_mask;
    logic per_channel;
  } mode_t;

  typedef struct packed {
    range_t  red_range;
    range_t  green_range;
    range_t  blue_range;
    chan_t   soften;
    colour_t clear_colour;
    mode_t   mode;
  } cfg_t;

  // key and base pixel moving down the pipe
  typedef struct packed {
    pixel_t key;
    pixel_t base;
  } pair_t;

  // match results from the compare stage
  typedef struct packed {
    logic clear;
    logic red_in;
    logic green_in;
    logic blue_in;
    logic green_nz;
    logic blue_nz;
  } match_t;

endpackage

[src/chroma_key_pixel_replace.sv]
// chroma key pixel replace top level: config registers and three stage pipe
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------
//  config   | wr_en            | wr_index, wr_data
//  input    | start, busy      | key_red..key_alpha, base_red..base_alpha
//  result   | done             | out_red, out_green, out_blue, out_alpha
//
// one word enters per clock; its result shows on done
// once it has passed the three register stages: spill, compare, select
// busy is high only during reset; no stage ever holds a word back
// the receiver cannot stall, so results are not held beyond their cycle
// reset clears the config registers and all stage valid bits
module chroma_key_pixel_replace (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [ckpr_pkg::INDEX_W-1:0]  wr_index,
  input  logic [ckpr_pkg::CFG_W-1:0]    wr_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [7:0]                    key_red,
  input  logic [7:0]                    key_green,
  input  logic [7:0]                    key_blue,
  input  logic [7:0]                    key_alpha,
  input  logic [7:0]                    base_red,
  input  logic [7:0]                    base_green,
  input  logic [7:0]                    base_blue,
  input  logic [7:0]                    base_alpha,
  output logic                          done,
  output logic [7:0]                    out_red,
  output logic [7:0]                    out_green,
  output logic [7:0]                    out_blue,
  output logic [7:0]                    out_alpha
);

  ckpr_pkg::cfg_t   cfg;
  ckpr_pkg::pair_t  in_pair;
  logic             accept;
  logic             s1_valid;
  ckpr_pkg::pair_t  s1_pair;
  logic             s2_valid;
  ckpr_pkg::pair_t  s2_pair;
  ckpr_pkg::match_t s2_match;
  ckpr_pkg::pixel_t result;

  assign busy   = rst;
  assign accept = start && !busy;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        ckpr_pkg::REG_RED_RANGE:   cfg.red_range    <= wr_data[15:0];
        ckpr_pkg::REG_GREEN_RANGE: cfg.green_range  <= wr_data[15:0];
        ckpr_pkg::REG_BLUE_RANGE:  cfg.blue_range   <= wr_data[15:0];
        ckpr_pkg::REG_SOFTEN:      cfg.soften       <= wr_data[7:0];
        ckpr_pkg::REG_CLEAR:       cfg.clear_colour <= wr_data[23:0];
        ckpr_pkg::REG_MODE:        cfg.mode         <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  // input word
  assign in_pair.key  = {key_red, key_green, key_blue, key_alpha};
  assign in_pair.base = {base_red, base_green, base_blue, base_alpha};

  ckpr_spill u_spill (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (accept),
    .in_pair  (in_pair),
    .valid    (s1_valid),
    .pair     (s1_pair)
  );

  ckpr_match u_match (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s1_valid),
    .in_pair  (s1_pair),
    .valid    (s2_valid),
    .pair     (s2_pair),
    .match    (s2_match)
  );

  ckpr_select u_select (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s2_valid),
    .in_pair  (s2_pair),
    .in_match (s2_match),
    .valid    (done),
    .pixel    (result)
  );

  assign out_red   = result.r;
  assign out_green = result.g;
  assign out_blue  = result.b;
  assign out_alpha = result.a;

  // every accepted word comes out on done after the spill, compare and select registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("accepted word did not reach the output");

  // no result without a word accepted through the spill, compare and select registers
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result strobe without an accepted word");

  // a clear colour match always passes the base alpha through
  a_clear_alpha: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_match.clear) |=> (done && out_alpha == $past(s2_pair.base.a)))
    else $error("clear colour match lost the base alpha");

endmodule

[src/ckpr_spill.sv]
// stage one: input register and blue spill suppression
module ckpr_spill (
  input  logic            clk,
  input  logic            rst,
  input  ckpr_pkg::cfg_t  cfg,
  input  logic            in_valid,
  input  ckpr_pkg::pair_t in_pair,
  output logic            valid,
  output ckpr_pkg::pair_t pair
);

  ckpr_pkg::chan_t floored;
  ckpr_pkg::chan_t blue_next;
  ckpr_pkg::pair_t pair_next;

  // blue above green is pulled down by soften, floored at zero then at green
  always_comb begin
    floored   = (cfg.soften >= in_pair.key.b) ? '0 : in_pair.key.b - cfg.soften;
    blue_next = in_pair.key.b;
    if (in_pair.key.b > in_pair.key.g) begin
      blue_next = (floored < in_pair.key.g) ? in_pair.key.g : floored;
    end
    pair_next       = in_pair;
    pair_next.key.b = blue_next;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    pair <= pair_next;
  end

endmodule

[src/ckpr_match.sv]
// stage two: clear colour match and key range compares
module ckpr_match (
  input  logic             clk,
  input  logic             rst,
  input  ckpr_pkg::cfg_t   cfg,
  input  logic             in_valid,
  input  ckpr_pkg::pair_t  in_pair,
  output logic             valid,
  output ckpr_pkg::pair_t  pair,
  output ckpr_pkg::match_t match
);

  ckpr_pkg::match_t match_next;

  // inclusive range tests, clear colour equality and nonzero flags
  always_comb begin
    match_next.clear    = (in_pair.key.r == cfg.clear_colour.r) &&
                          (in_pair.key.g == cfg.clear_colour.g) &&
                          (in_pair.key.b == cfg.clear_colour.b);
    match_next.red_in   = (in_pair.key.r >= cfg.red_range.lo) &&
                          (in_pair.key.r <= cfg.red_range.hi);
    match_next.green_in = (in_pair.key.g >= cfg.green_range.lo) &&
                          (in_pair.key.g <= cfg.green_range.hi);
    match_next.blue_in  = (in_pair.key.b >= cfg.blue_range.lo) &&
                          (in_pair.key.b <= cfg.blue_range.hi);
    match_next.green_nz = (in_pair.key.g != '0);
    match_next.blue_nz  = (in_pair.key.b != '0);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  // word and flags
  always_ff @(posedge clk) begin
    pair  <= in_pair;
    match <= match_next;
  end

endmodule

[src/ckpr_select.sv]
// stage three: channel replacement and output register
module ckpr_select (
  input  logic             clk,
  input  logic             rst,
  input  ckpr_pkg::cfg_t   cfg,
  input  logic             in_valid,
  input  ckpr_pkg::pair_t  in_pair,
  input  ckpr_pkg::match_t in_match,
  output logic             valid,
  output ckpr_pkg::pixel_t pixel
);

  ckpr_pkg::pixel_t pixel_next;
  logic             whole;

  // per-channel swap, or whole pixel swap with optional white fill
  always_comb begin
    pixel_next = in_pair.key;
    whole      = in_match.clear ||
                 (in_match.red_in && in_match.green_in && in_match.blue_in);
    if (cfg.mode.per_channel) begin
      if (in_match.clear || in_match.red_in) begin
        pixel_next.r = in_pair.base.r;
      end
      if (in_match.clear || (in_match.green_nz && in_match.green_in)) begin
        pixel_next.g = in_pair.base.g;
      end
      if (in_match.clear || (in_match.blue_nz && in_match.blue_in)) begin
        pixel_next.b = in_pair.base.b;
      end
      if (in_match.clear) begin
        pixel_next.a = in_pair.base.a;
      end
    end else if (whole) begin
      pixel_next = in_pair.base;
    end else if (cfg.mode.white_mask) begin
      pixel_next = {4{ckpr_pkg::CHAN_MAX}};
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= in_valid;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    pixel <= pixel_next;
  end

endmodule
